### src/vptw_pkg.sv
// ----------------------------------------------------------------------------
// Vertex projection package
// Shared types, constants and fixed-point helpers for the vertex projection
// pipeline.
// ----------------------------------------------------------------------------
package vptw_pkg;

  localparam int unsigned CW        = 32;
  localparam int unsigned FB        = 16;
  localparam int unsigned VW        = 16;
  localparam int unsigned DIV_STEPS = CW;
  localparam int unsigned XF_LAT    = 4;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned WIN_LAT   = 4;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned OUT_USER_W = 2;

  typedef logic signed [CW-1:0]   word_t;
  typedef logic signed [2*CW-1:0] prod_t;
  typedef logic signed [VW-1:0]   vpw_t;
  typedef word_t [3:0]            vec4_t;
  typedef vec4_t [3:0]            mat4_t;
  typedef word_t [2:0]            vec3_t;
  typedef vpw_t [3:0]             vport_t;

  localparam word_t WORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam word_t ONE      = word_t'(64'd1 << FB);
  localparam word_t HALF     = word_t'(64'd1 << (FB - 1));

  typedef enum logic [1:0] {
    CMD_MAT_WRITE = 2'd0,
    CMD_VP_WRITE  = 2'd1,
    CMD_PROJECT   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_W_ZERO = 2'd1,
    ST_SAT    = 2'd2
  } status_e;

  typedef struct packed {
    logic  sat;
    word_t val;
  } satw_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] cmd;
    logic       sel;
    logic [3:0] idx;
    word_t      mval;
    vpw_t       vval;
    logic       sat;
    logic       wzero;
  } side_t;

  function automatic satw_t from_mag(logic neg, logic [CW-1:0] mag, logic over);
    satw_t r;
    if (neg) begin
      if (over || (mag > {1'b1, {(CW-1){1'b0}}})) begin
        r.sat = 1'b1;
        r.val = WORD_MIN;
      end else begin
        r.sat = 1'b0;
        r.val = word_t'({CW{1'b0}} - mag);
      end
    end else begin
      if (over || mag[CW-1]) begin
        r.sat = 1'b1;
        r.val = WORD_MAX;
      end else begin
        r.sat = 1'b0;
        r.val = word_t'(mag);
      end
    end
    return r;
  endfunction

  function automatic satw_t fmul_fin(prod_t p);
    logic [2*CW-1:0] mag;
    mag = p[2*CW-1] ? (~p + 1'b1) : p;
    return from_mag(p[2*CW-1], mag[FB+CW-1:FB], |mag[2*CW-1:FB+CW]);
  endfunction

  function automatic satw_t sat_add(word_t a, word_t b);
    logic signed [CW:0] s;
    satw_t r;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      r.sat = 1'b1;
      r.val = s[CW] ? WORD_MIN : WORD_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[CW-1:0];
    end
    return r;
  endfunction

endpackage

### src/vptw_xform.sv
// ----------------------------------------------------------------------------
// Matrix-vector transform
// Four-stage pipelined 4x4 matrix times vector with saturating accumulation
// in column order.
// ----------------------------------------------------------------------------
module vptw_xform (
  input  logic            clk_i,
  input  logic            en_i,
  input  vptw_pkg::mat4_t mat_i,
  input  vptw_pkg::vec4_t vec_i,
  output vptw_pkg::vec4_t res_o,
  output logic            sat_o
);
  import vptw_pkg::*;

  prod_t      prod_q [4][4];
  satw_t      fm     [4][4];
  satw_t      add1   [4];
  satw_t      add2   [4];
  satw_t      add3   [4];
  word_t      s01_q  [4];
  word_t      p2_q   [4];
  word_t      p3_q   [4];
  word_t      s012_q [4];
  word_t      p3b_q  [4];
  logic [3:0] sat2_q;
  logic [3:0] sat3_q;
  logic       sat_all;
  vec4_t      res_q;
  logic       sat_q;

  always_comb begin
    sat_all = |sat3_q;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fm[c][r] = fmul_fin(prod_q[c][r]);
      end
    end
    for (int r = 0; r < 4; r++) begin
      add1[r] = sat_add(fm[0][r].val, fm[1][r].val);
      add2[r] = sat_add(s01_q[r], p2_q[r]);
      add3[r] = sat_add(s012_q[r], p3b_q[r]);
      sat_all = sat_all | add3[r].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          prod_q[c][r] <= $signed(mat_i[c][r]) * $signed(vec_i[c]);
        end
      end
      for (int r = 0; r < 4; r++) begin
        s01_q[r]  <= add1[r].val;
        p2_q[r]   <= fm[2][r].val;
        p3_q[r]   <= fm[3][r].val;
        sat2_q[r] <= fm[0][r].sat | fm[1][r].sat | fm[2][r].sat | fm[3][r].sat | add1[r].sat;
        s012_q[r] <= add2[r].val;
        p3b_q[r]  <= p3_q[r];
        sat3_q[r] <= sat2_q[r] | add2[r].sat;
        res_q[r]  <= add3[r].val;
      end
      sat_q <= sat_all;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### src/vptw_div.sv
// ----------------------------------------------------------------------------
// Perspective divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
module vptw_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  vptw_pkg::vec3_t num_i,
  input  vptw_pkg::word_t den_i,
  output vptw_pkg::vec3_t quo_o,
  output logic            sat_o
);
  import vptw_pkg::*;

  logic [CW-1:0] ua     [3];
  logic [CW-1:0] ud;
  logic [CW-1:0] rem_q  [DIV_STEPS+1][3];
  logic [CW-1:0] nb_q   [DIV_STEPS+1][3];
  logic [CW-1:0] rem_d  [DIV_STEPS][3];
  logic [CW-1:0] nb_d   [DIV_STEPS][3];
  logic [CW-1:0] ud_q   [DIV_STEPS+1];
  logic [2:0]    neg_q  [DIV_STEPS+1];
  logic [2:0]    over_q [DIV_STEPS+1];
  satw_t         fin    [3];
  vec3_t         quo_q;
  logic          sat_q;

  always_comb begin
    logic [CW:0] t;
    logic [CW:0] dif;
    logic        ge;
    ud = den_i[CW-1] ? ({CW{1'b0}} - den_i) : den_i;
    for (int l = 0; l < 3; l++) begin
      ua[l] = num_i[l][CW-1] ? ({CW{1'b0}} - num_i[l]) : num_i[l];
      fin[l] = from_mag(neg_q[DIV_STEPS][l], nb_q[DIV_STEPS][l], over_q[DIV_STEPS][l]);
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < 3; l++) begin
        t   = {rem_q[k][l], nb_q[k][l][CW-1]};
        dif = t - {1'b0, ud_q[k]};
        ge  = t >= {1'b0, ud_q[k]};
        rem_d[k][l] = ge ? dif[CW-1:0] : t[CW-1:0];
        nb_d[k][l]  = {nb_q[k][l][CW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ud_q[0] <= ud;
      for (int l = 0; l < 3; l++) begin
        neg_q[0][l]  <= num_i[l][CW-1] ^ den_i[CW-1];
        over_q[0][l] <= {{(CW-FB){1'b0}}, ua[l][CW-1:CW-FB]} >= ud;
        rem_q[0][l]  <= {{(CW-FB){1'b0}}, ua[l][CW-1:CW-FB]};
        nb_q[0][l]   <= {ua[l][CW-FB-1:0], {FB{1'b0}}};
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        ud_q[k+1]   <= ud_q[k];
        neg_q[k+1]  <= neg_q[k];
        over_q[k+1] <= over_q[k];
        for (int l = 0; l < 3; l++) begin
          rem_q[k+1][l] <= rem_d[k][l];
          nb_q[k+1][l]  <= nb_d[k][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        quo_q[l] <= fin[l].val;
      end
      sat_q <= fin[0].sat | fin[1].sat | fin[2].sat;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule

### src/vptw_win.sv
// ----------------------------------------------------------------------------
// Viewport mapping
// Four-stage pipeline that maps normalized coordinates to window x and y
// through the viewport and depth to the unit range.
// ----------------------------------------------------------------------------
module vptw_win (
  input  logic             clk_i,
  input  logic             en_i,
  input  vptw_pkg::vec3_t  ndc_i,
  input  vptw_pkg::vport_t vp_i,
  output vptw_pkg::vec3_t  win_o,
  output logic             sat_o
);
  import vptw_pkg::*;

  word_t         t     [3];
  logic [CW-1:0] mag   [3];
  logic [CW-1:0] hm    [3];
  word_t         t_q   [3];
  word_t         o_q   [2];
  word_t         s_q   [2];
  prod_t         p_q   [2];
  word_t         o2_q  [2];
  word_t         tz2_q;
  satw_t         fm    [2];
  word_t         f_q   [2];
  word_t         o3_q  [2];
  word_t         tz3_q;
  logic          sat3_q;
  satw_t         sum   [2];
  vec3_t         win_q;
  logic          sat_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = ndc_i[l][CW-1] ? ({CW{1'b0}} - ndc_i[l]) : ndc_i[l];
      hm[l]  = mag[l] >> 1;
      t[l]   = word_t'(ndc_i[l][CW-1] ? ({CW{1'b0}} - hm[l]) : hm[l]) + HALF;
    end
    for (int l = 0; l < 2; l++) begin
      fm[l]  = fmul_fin(p_q[l]);
      sum[l] = sat_add(o3_q[l], f_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        t_q[l] <= t[l];
      end
      for (int l = 0; l < 2; l++) begin
        o_q[l]  <= word_t'({vp_i[l], {FB{1'b0}}});
        s_q[l]  <= word_t'({vp_i[l+2], {FB{1'b0}}});
        p_q[l]  <= $signed(s_q[l]) * $signed(t_q[l]);
        o2_q[l] <= o_q[l];
        f_q[l]  <= fm[l].val;
        o3_q[l] <= o2_q[l];
        win_q[l] <= sum[l].val;
      end
      tz2_q    <= t_q[2];
      tz3_q    <= tz2_q;
      sat3_q   <= fm[0].sat | fm[1].sat;
      win_q[2] <= tz3_q;
      sat_q    <= sat3_q | sum[0].sat | sum[1].sat;
    end
  end

  assign win_o = win_q;
  assign sat_o = sat_q;

endmodule

### src/vertex_project_to_window_unit.sv
// ----------------------------------------------------------------------------
// Vertex projection to window coordinates
// Loads model, projection and viewport state and projects points through
// them in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// Every input beat carries a command in tuser: a matrix element write, a
// viewport word write or a point to project. Every beat yields exactly one
// output beat, in order; writes report status ok with zero coordinates.
// A point is multiplied by the model and projection matrices, divided by
// clip w and mapped through the viewport; zero clip w reports an error
// with zero coordinates, and any overflow saturates and reports saturated.
// A write takes effect for every point that follows it on the stream.
// A beat passes through one input stage, the model and projection
// transforms, the divider (one quotient bit per stage), the viewport
// mapping and one output register.
// One beat is accepted every cycle while the output is not stalled.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and the input tready drops in the same cycle.
// Reset clears all matrices and viewport words to zero and empties the
// pipeline.
// ----------------------------------------------------------------------------
module vertex_project_to_window_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // index[3:0], matrix value[35:4], viewport value[51:36], x[83:52],
  // y[115:84], z[147:116], zero pad[151:148]
  input  logic [vptw_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // command[1:0], matrix select[2]
  input  logic [vptw_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // window x[31:0], window y[63:32], window depth[95:64]
  output logic [vptw_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status[1:0]
  output logic [vptw_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);
  import vptw_pkg::*;

  logic   adv;
  side_t  side0_d;
  side_t  side0_q;
  vec3_t  pt_q;
  side_t  d1_q [XF_LAT];
  side_t  d2_q [XF_LAT];
  side_t  d3_q [DIV_LAT];
  side_t  d4_q [WIN_LAT];
  side_t  side1x;
  side_t  side2x;
  side_t  side3x;
  side_t  fs;
  word_t  model_q [16];
  word_t  proj_q  [16];
  vport_t vp_q;
  mat4_t  mat1;
  vec4_t  vec1;
  mat4_t  mat2;
  vec4_t  xf1_res;
  logic   xf1_sat;
  vec4_t  xf2_res;
  logic   xf2_sat;
  vec3_t  num;
  vec3_t  div_res;
  logic   div_sat;
  vec3_t  win_res;
  logic   win_sat;
  logic   out_vld_q;
  logic [1:0] out_stat_d;
  logic [1:0] out_stat_q;
  vec3_t  out_win_d;
  vec3_t  out_win_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    side0_d.vld   = s_axis_tvalid_i;
    side0_d.cmd   = s_axis_tuser_i[1:0];
    side0_d.sel   = s_axis_tuser_i[2];
    side0_d.idx   = s_axis_tdata_i[3:0];
    side0_d.mval  = s_axis_tdata_i[35:4];
    side0_d.vval  = s_axis_tdata_i[51:36];
    side0_d.sat   = 1'b0;
    side0_d.wzero = 1'b0;

    for (int r = 0; r < 4; r++) begin
      mat1[0][r] = model_q[4'(12 + r)];
      for (int c = 0; c < 3; c++) begin
        mat1[c+1][r] = model_q[4'(c * 4 + r)];
      end
      for (int c = 0; c < 4; c++) begin
        mat2[c][r] = proj_q[4'(c * 4 + r)];
      end
    end
    vec1[0] = ONE;
    vec1[1] = pt_q[0];
    vec1[2] = pt_q[1];
    vec1[3] = pt_q[2];

    num[0] = xf2_res[0];
    num[1] = xf2_res[1];
    num[2] = xf2_res[2];

    side1x       = d1_q[XF_LAT-1];
    side1x.sat   = xf1_sat;
    side2x       = d2_q[XF_LAT-1];
    side2x.sat   = side2x.sat | xf2_sat;
    side2x.wzero = (xf2_res[3] == '0);
    side3x       = d3_q[DIV_LAT-1];
    side3x.sat   = side3x.sat | div_sat;
    fs           = d4_q[WIN_LAT-1];

    out_stat_d = ST_OK;
    out_win_d  = '0;
    if (fs.cmd == CMD_PROJECT) begin
      if (fs.wzero) begin
        out_stat_d = ST_W_ZERO;
      end else begin
        out_stat_d = (fs.sat || win_sat) ? ST_SAT : ST_OK;
        out_win_d  = win_res;
      end
    end
  end

  vptw_xform u_model (
    .clk_i (clk_i),
    .en_i  (adv),
    .mat_i (mat1),
    .vec_i (vec1),
    .res_o (xf1_res),
    .sat_o (xf1_sat)
  );

  vptw_xform u_proj (
    .clk_i (clk_i),
    .en_i  (adv),
    .mat_i (mat2),
    .vec_i (xf1_res),
    .res_o (xf2_res),
    .sat_o (xf2_sat)
  );

  vptw_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num),
    .den_i (xf2_res[3]),
    .quo_o (div_res),
    .sat_o (div_sat)
  );

  vptw_win u_win (
    .clk_i (clk_i),
    .en_i  (adv),
    .ndc_i (div_res),
    .vp_i  (vp_q),
    .win_o (win_res),
    .sat_o (win_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q   <= '0;
      d1_q      <= '{default: '0};
      d2_q      <= '{default: '0};
      d3_q      <= '{default: '0};
      d4_q      <= '{default: '0};
      model_q   <= '{default: '0};
      proj_q    <= '{default: '0};
      vp_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      side0_q <= side0_d;
      d1_q[0] <= side0_q;
      d2_q[0] <= side1x;
      d3_q[0] <= side2x;
      d4_q[0] <= side3x;
      for (int i = 1; i < XF_LAT; i++) begin
        d1_q[i] <= d1_q[i-1];
        d2_q[i] <= d2_q[i-1];
      end
      for (int i = 1; i < DIV_LAT; i++) begin
        d3_q[i] <= d3_q[i-1];
      end
      for (int i = 1; i < WIN_LAT; i++) begin
        d4_q[i] <= d4_q[i-1];
      end
      if (side0_q.vld && side0_q.cmd == CMD_MAT_WRITE && !side0_q.sel) begin
        model_q[side0_q.idx] <= side0_q.mval;
      end
      if (side1x.vld && side1x.cmd == CMD_MAT_WRITE && side1x.sel) begin
        proj_q[side1x.idx] <= side1x.mval;
      end
      if (side3x.vld && side3x.cmd == CMD_VP_WRITE && side3x.idx[3:2] == 2'b00) begin
        vp_q[side3x.idx[1:0]] <= side3x.vval;
      end
      out_vld_q <= fs.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[0]    <= s_axis_tdata_i[83:52];
      pt_q[1]    <= s_axis_tdata_i[115:84];
      pt_q[2]    <= s_axis_tdata_i[147:116];
      out_stat_q <= out_stat_d;
      out_win_q  <= out_win_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tdata_o  = {out_win_q[2], out_win_q[1], out_win_q[0]};

endmodule

### test/tb_vertex_project_to_window_unit.sv
// ----------------------------------------------------------------------------
// Vertex projection testbench
// Drives matrix, viewport, project and unused-command beats into the unit
// with random idling on both sides, predicts each result in fixed point and
// compares every output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_vertex_project_to_window_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vptw_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
  } window_t;

  class projection_scoreboard;
    longint model_m[16];
    longint proj_m[16];
    longint vport[4];
    bit     sat_hit;
    window_t pending[$];
    int     fails;

    function new();
      foreach (model_m[i]) begin
        model_m[i] = 0;
        proj_m[i] = 0;
      end
      foreach (vport[i]) vport[i] = 0;
      fails = 0;
    endfunction

    function longint sat_mag(bit neg, logic [127:0] mag);
      if (neg) begin
        if (mag > 128'h8000_0000) begin
          sat_hit = 1;
          return -64'sh8000_0000;
        end
        return -longint'(mag[63:0]);
      end
      if (mag > 128'h7fff_ffff) begin
        sat_hit = 1;
        return 64'sh7fff_ffff;
      end
      return longint'(mag[63:0]);
    endfunction

    function longint clamp32(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return sat_mag(v < 0, m);
    endfunction

    function longint qmul(longint a, longint b);
      logic [127:0] m;
      m = (128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b)) >> 16;
      return sat_mag((a < 0) != (b < 0), m);
    endfunction

    function longint qdiv(longint a, longint d);
      logic [127:0] m;
      m = (128'((a < 0) ? -a : a) << 16) / 128'((d < 0) ? -d : d);
      return sat_mag((a < 0) != (d < 0), m);
    endfunction

    function longint to_win(longint org, longint sz, longint ndc);
      longint t;
      t = clamp32(qmul(ndc, 32768) + 32768);
      return clamp32(clamp32(org * 65536) + qmul(clamp32(sz * 65536), t));
    endfunction

    function void note_beat(logic [1:0] cmd, logic sel, logic [3:0] idx,
                            logic [31:0] mv, logic [15:0] vv,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      window_t r;
      longint pt[3];
      longint eye[4];
      longint clip[4];
      longint acc;
      r = '0;
      sat_hit = 0;
      if (cmd == CMD_MAT_WRITE) begin
        if (sel) proj_m[idx] = longint'($signed(mv));
        else model_m[idx] = longint'($signed(mv));
      end else if (cmd == CMD_VP_WRITE) begin
        if (idx < 4) vport[idx] = longint'($signed(vv));
      end else if (cmd == CMD_PROJECT) begin
        pt[0] = longint'($signed(px));
        pt[1] = longint'($signed(py));
        pt[2] = longint'($signed(pz));
        for (int row = 0; row < 4; row++) begin
          acc = model_m[12 + row];
          for (int col = 0; col < 3; col++)
            acc = clamp32(acc + qmul(model_m[col * 4 + row], pt[col]));
          eye[row] = acc;
        end
        for (int row = 0; row < 4; row++) begin
          acc = 0;
          for (int col = 0; col < 4; col++)
            acc = clamp32(acc + qmul(proj_m[col * 4 + row], eye[col]));
          clip[row] = acc;
        end
        if (clip[3] == 0) begin
          r.status = ST_W_ZERO;
        end else begin
          r.wx = 32'(to_win(vport[0], vport[2], qdiv(clip[0], clip[3])));
          r.wy = 32'(to_win(vport[1], vport[3], qdiv(clip[1], clip[3])));
          r.wz = 32'(clamp32(qmul(qdiv(clip[2], clip[3]), 32768) + 32768));
          r.status = sat_hit ? ST_SAT : ST_OK;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_beat(logic [1:0] st, logic [95:0] d);
      window_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat status=%0d data=%h", st, d);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        fails++;
      end
      if (d[31:0] !== e.wx) begin
        $error("window_x expected %h actual %h", e.wx, d[31:0]);
        fails++;
      end
      if (d[63:32] !== e.wy) begin
        $error("window_y expected %h actual %h", e.wy, d[63:32]);
        fails++;
      end
      if (d[95:64] !== e.wz) begin
        $error("window_depth expected %h actual %h", e.wz, d[95:64]);
        fails++;
      end
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid_i = 0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  projection_scoreboard window_sb = new();
  bit  calm_phase = 0;
  bit  long_hold = 0;
  longint cycle_count = 0;

  vertex_project_to_window_unit i_dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      window_sb.note_beat(s_axis_tuser_i[1:0], s_axis_tuser_i[2], s_axis_tdata_i[3:0],
                          s_axis_tdata_i[35:4], s_axis_tdata_i[51:36],
                          s_axis_tdata_i[83:52], s_axis_tdata_i[115:84],
                          s_axis_tdata_i[147:116]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      window_sb.check_beat(m_axis_tuser_o, m_axis_tdata_o);
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready_i <= 0;
        repeat (200) @(posedge clk_i);
        long_hold = 0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17);
        m_axis_tready_i <= 0;
        repeat (hold) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic sel, logic [3:0] idx, logic [31:0] mv,
                           logic [15:0] vv, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz);
    if (!calm_phase && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid_i <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= {sel, cmd};
    s_axis_tdata_i <= {4'b0, pz, py, px, vv, mv, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic idle_input();
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic write_matrix(logic sel, logic [3:0] idx, logic [31:0] v);
    send_beat(CMD_MAT_WRITE, sel, idx, v, 16'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic write_viewport(logic [3:0] idx, logic [15:0] v);
    send_beat(CMD_VP_WRITE, 1'($urandom), idx, $urandom, v, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_beat(CMD_PROJECT, 1'($urandom), 4'($urandom), $urandom, 16'($urandom), x, y, z);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 16)));
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // Loads a sane perspective-like setup with random content.
  task automatic load_scene();
    for (int i = 0; i < 16; i++) begin
      write_matrix(0, 4'(i), (i % 5 == 0) ? 32'h0001_0000 + ($urandom_range(0, 65535))
                                          : ($urandom_range(0, 3) == 0 ? rand_coord() : 0));
      write_matrix(1, 4'(i), (i % 5 == 0 || i == 11) ? 32'h0001_0000
                             : ($urandom_range(0, 3) == 0 ? rand_coord() : 0));
    end
    write_viewport(0, 16'($urandom));
    write_viewport(1, 16'($urandom_range(0, 200)));
    write_viewport(2, 16'($urandom_range(0, 1920)));
    write_viewport(3, 16'($urandom_range(0, 1080)));
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Zero stores give clip w zero; unused command is ignored.
    project(32'h7fff_ffff, 32'h8000_0000, 0);
    send_beat(2'd3, 1, 4'hf, 32'hffff_ffff, 16'hffff, '1, '1, '1);
    write_matrix(0, 15, 32'h0001_0000);
    write_matrix(1, 15, 32'h0001_0000);
    write_matrix(1, 0, 32'h7fff_ffff);
    write_matrix(1, 5, 32'h8000_0000);
    write_matrix(1, 10, 32'h0001_0000);
    write_viewport(2, 16'h7fff);
    write_viewport(3, 16'h8000);
    write_viewport(9, 16'h1234);
    project(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    write_matrix(0, 12, 32'h7fff_ffff);
    write_matrix(0, 13, 32'h8000_0000);
    project(0, 0, 0);
    load_scene();
    project(0, 0, 0);
    project(32'h0000_8000, 32'h0000_4000, 32'hffff_0000);
    // Pause until the pipeline drains completely.
    idle_input();
    wait (window_sb.pending.size() == 0);
    long_hold = 1;
    sent = 0;
    while (sent < 450) begin
      if (sent > 400) calm_phase = 1;
      case ($urandom_range(0, 19))
        0: begin
          load_scene();
          sent += 36;
        end
        1: begin
          write_matrix(1'($urandom), 4'($urandom),
                       $urandom_range(0, 1) ? $urandom : rand_coord());
          sent++;
        end
        2: begin
          write_viewport(4'($urandom), 16'($urandom));
          sent++;
        end
        3: begin
          send_beat(2'd3, 1'($urandom), 4'($urandom), $urandom, 16'($urandom), $urandom,
                    $urandom, $urandom);
          sent++;
        end
        default: begin
          project(rand_coord(), rand_coord(), rand_coord());
          sent++;
        end
      endcase
    end
    idle_input();
    wait (window_sb.pending.size() == 0);
    repeat (100) @(posedge clk_i);
    if (window_sb.fails == 0 && window_sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
src/vptw_pkg.sv
src/vptw_xform.sv
src/vptw_div.sv
src/vptw_win.sv
src/vertex_project_to_window_unit.sv
test/tb_vertex_project_to_window_unit.sv
